FILE: rtl/tax_id_check_digit_validator_core_defines.svh
// Assertion macros shared by the tax identifier validator RTL.
// Expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TAX_ID_CHECK_DIGIT_VALIDATOR_CORE_DEFINES_SVH
`define TAX_ID_CHECK_DIGIT_VALIDATOR_CORE_DEFINES_SVH

// Clocked property, off while reset is held.
`define TIDV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked property that also holds during reset.
`define TIDV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

FILE: rtl/tidv_pkg.sv
// Types, constants and helper functions for the tax identifier validator.
// No dependencies; imported by tidv_step and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tidv_pkg;

    localparam logic       KIND_CPF      = 1'b0;
    localparam logic       KIND_CNPJ     = 1'b1;
    localparam logic [7:0] ASCII_ZERO    = 8'd48;
    localparam logic [7:0] ASCII_NINE    = 8'd57;
    localparam logic [3:0] POS_MAX       = 4'd15;
    localparam logic [3:0] CPF_CHK1_POS  = 4'd9;
    localparam logic [3:0] CPF_CHK2_POS  = 4'd10;
    localparam logic [3:0] CNPJ_CHK1_POS = 4'd12;
    localparam logic [3:0] CNPJ_CHK2_POS = 4'd13;
    // floor(x * 93 / 1024) is floor(x / 11) or one less for x below 1024
    localparam logic [6:0] MOD11_RECIP   = 7'd93;
    localparam int         MOD11_SHIFT   = 10;

    typedef enum logic [2:0] {
        RSN_OK           = 3'd0,
        RSN_LENGTH       = 3'd1,
        RSN_ALL_SAME     = 3'd2,
        RSN_FIRST_DIGIT  = 3'd3,
        RSN_SECOND_DIGIT = 3'd4,
        RSN_NON_DIGIT    = 3'd5
    } t_reason;

    typedef struct packed {
        logic [3:0] pos;
        logic       kind;
        logic [9:0] first_sum;
        logic [9:0] second_sum;
        logic [3:0] lead;
        logic       all_same;
        logic       non_digit;
        logic [3:0] chk1;
        logic [3:0] chk2;
    } t_state;

    localparam t_state STATE_RESET = '{
        pos: 4'd0, kind: KIND_CPF, first_sum: 10'd0, second_sum: 10'd0,
        lead: 4'd0, all_same: 1'b1, non_digit: 1'b0, chk1: 4'd0, chk2: 4'd0
    };

    function automatic logic [3:0] first_weight(input logic kind, input logic [3:0] idx);
        logic [3:0] w;
        if (kind == KIND_CPF) begin
            w = (idx <= 4'd8) ? 4'd10 - idx : 4'd0;
        end else if (idx > 4'd11) begin
            w = 4'd0;
        end else begin
            w = (idx < 4'd4) ? 4'd5 - idx : 4'd13 - idx;
        end
        return w;
    endfunction

    function automatic logic [3:0] second_weight(input logic kind, input logic [3:0] idx);
        logic [3:0] w;
        if (kind == KIND_CPF) begin
            w = (idx <= 4'd9) ? 4'd11 - idx : 4'd0;
        end else if (idx > 4'd12) begin
            w = 4'd0;
        end else begin
            w = (idx < 4'd5) ? 4'd6 - idx : 4'd14 - idx;
        end
        return w;
    endfunction

    // Expected check digit: remainder mod 11 below 2 gives 0, else 11 - remainder.
    function automatic logic [3:0] mod11_digit(input logic [9:0] sum);
        logic [16:0] prod;
        logic [6:0]  q;
        logic [10:0] q11;
        logic [4:0]  r;
        logic [3:0]  rr;
        logic [3:0]  d;
        prod = {7'd0, sum} * {10'd0, MOD11_RECIP};
        q    = prod[MOD11_SHIFT +: 7];
        q11  = {1'b0, q, 3'b000} + {3'b000, q, 1'b0} + {4'd0, q};
        r    = 5'(sum - q11[9:0]);
        rr   = (r >= 5'd11) ? 4'(r - 5'd11) : r[3:0];
        d    = (rr < 4'd2) ? 4'd0 : 4'd11 - rr;
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tax_id_check_digit_validator_core.sv
// Top level of the CPF / CNPJ mod-11 check digit validator.
// Depends on tidv_pkg, tidv_step and tax_id_check_digit_validator_core_defines.svh.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_char_code, i_command, i_last_char
//   out     | output    | o_out_valid / i_out_stall| o_id_valid, o_fail_reason
//
// One character per cycle while o_in_stall is low; after its last character is accepted,
// a verdict leaves through the input register, then the result register.
// The running sums and flags advance by one small multiply-accumulate per character.
// Reset (synchronous, active low) empties both registers and clears the running state.
// A character that makes no verdict never waits on the output side; a last character
// waits only while an earlier verdict is stalled, and then the input stalls too.
`timescale 1ns / 1ps
`default_nettype none
`include "tax_id_check_digit_validator_core_defines.svh"

module tax_id_check_digit_validator_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_command,
    input  logic       i_last_char,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_id_valid,
    output logic [2:0] o_fail_reason
);
    import tidv_pkg::*;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_cmd;
    logic       r_in_last;
    // running identifier state
    t_state     r_state;
    t_state     n_state;
    // result register
    logic       r_out_valid;
    logic       r_out_id_valid;
    t_reason    r_out_reason;

    logic       w_in_accept;
    logic       w_adv;
    logic       w_id_valid;
    t_reason    w_reason;

    tidv_step u_step (
        .i_state       (r_state),
        .i_char_code   (r_in_char),
        .i_command     (r_in_cmd),
        .i_last_char   (r_in_last),
        .o_next        (n_state),
        .o_id_valid    (w_id_valid),
        .o_fail_reason (w_reason)
    );

    // Advance the held item unless it makes a verdict and the result slot stays full.
    assign w_adv       = r_in_valid && (!r_in_last || !r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_adv;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            // input register: load on accept, drop once advanced
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_state <= n_state;
            end
            // result register: fill on a verdict, empty when taken
            if (w_adv && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_char <= i_char_code;
            r_in_cmd  <= i_command;
            r_in_last <= i_last_char;
        end
        if (w_adv && r_in_last) begin
            r_out_id_valid <= w_id_valid;
            r_out_reason   <= w_reason;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_id_valid    = r_out_id_valid;
    assign o_fail_reason = r_out_reason;

    `TIDV_ASSERT(a_pass_matches_reason, o_out_valid |-> (o_id_valid == (o_fail_reason == RSN_OK)), "id_valid disagrees with fail_reason")
    `TIDV_ASSERT(a_result_from_last, $rose(o_out_valid) |-> $past(r_in_valid && r_in_last), "result without a last character")
    `TIDV_ASSERT(a_verdict_clears_pos, (w_adv && r_in_last) |=> (r_state.pos == 4'd0), "position not cleared after a verdict")
    `TIDV_ASSERT_ALWAYS(a_stall_cause, o_in_stall |-> (r_in_valid && r_in_last && r_out_valid), "input stalled without a blocked verdict")

endmodule

`default_nettype wire

FILE: rtl/tidv_step.sv
// Per-character update of the validator state and the verdict on the last character.
// Depends on tidv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tidv_step (
    input  tidv_pkg::t_state  i_state,
    input  logic [7:0]        i_char_code,
    input  logic              i_command,
    input  logic              i_last_char,
    output tidv_pkg::t_state  o_next,
    output logic              o_id_valid,
    output tidv_pkg::t_reason o_fail_reason
);
    import tidv_pkg::*;

    logic       w_first;
    logic       w_is_digit;
    logic [3:0] w_digit;
    logic       w_kind;
    t_state     w_base;
    t_state     w_upd;
    logic [7:0] w_prod1;
    logic [7:0] w_prod2;
    logic [3:0] w_chk1_pos;
    logic [3:0] w_chk2_pos;
    t_reason    w_reason;

    assign w_first    = (i_state.pos == 4'd0);
    assign w_is_digit = i_char_code inside {[ASCII_ZERO:ASCII_NINE]};
    // '0'..'9' carry their value in the low nibble
    assign w_digit    = w_is_digit ? i_char_code[3:0] : 4'd0;
    assign w_kind     = w_first ? i_command : i_state.kind;
    assign w_base     = w_first ? STATE_RESET : i_state;
    assign w_chk1_pos = (w_kind == KIND_CNPJ) ? CNPJ_CHK1_POS : CPF_CHK1_POS;
    assign w_chk2_pos = (w_kind == KIND_CNPJ) ? CNPJ_CHK2_POS : CPF_CHK2_POS;
    assign w_prod1    = {4'd0, w_digit} * {4'd0, first_weight(w_kind, i_state.pos)};
    assign w_prod2    = {4'd0, w_digit} * {4'd0, second_weight(w_kind, i_state.pos)};

    always_comb begin
        w_upd            = w_base;
        w_upd.kind       = w_kind;
        w_upd.lead       = w_first ? w_digit : w_base.lead;
        w_upd.all_same   = w_first ? 1'b1 : (w_base.all_same && (w_digit == w_base.lead));
        w_upd.non_digit  = w_base.non_digit || !w_is_digit;
        w_upd.first_sum  = w_base.first_sum + {2'b00, w_prod1};
        w_upd.second_sum = w_base.second_sum + {2'b00, w_prod2};
        w_upd.chk1       = (i_state.pos == w_chk1_pos) ? w_digit : w_base.chk1;
        w_upd.chk2       = (i_state.pos == w_chk2_pos) ? w_digit : w_base.chk2;
        w_upd.pos        = (i_state.pos == POS_MAX) ? POS_MAX : i_state.pos + 4'd1;
    end

    // At the correct final position both weights are zero, so the held sums
    // already equal the updated ones.
    always_comb begin
        if (i_state.pos != w_chk2_pos) begin
            w_reason = RSN_LENGTH;
        end else if (w_upd.non_digit) begin
            w_reason = RSN_NON_DIGIT;
        end else if (w_upd.all_same) begin
            w_reason = RSN_ALL_SAME;
        end else if (mod11_digit(i_state.first_sum) != w_upd.chk1) begin
            w_reason = RSN_FIRST_DIGIT;
        end else if (mod11_digit(i_state.second_sum) != w_upd.chk2) begin
            w_reason = RSN_SECOND_DIGIT;
        end else begin
            w_reason = RSN_OK;
        end
    end

    always_comb begin
        if (i_last_char) begin
            o_next      = STATE_RESET;
            o_next.kind = w_kind;
        end else begin
            o_next = w_upd;
        end
    end

    assign o_fail_reason = w_reason;
    assign o_id_valid    = (w_reason == RSN_OK);

endmodule

`default_nettype wire
